@@ src/bounded_sequence_deque_unit_assert.svh @@
// assertion macros used by the checker file
// no dependencies; each macro expects clk_i and rst_ni in scope
`ifndef BOUNDED_SEQUENCE_DEQUE_UNIT_ASSERT_SVH
`define BOUNDED_SEQUENCE_DEQUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsd assertion failed");

// next-cycle implication, disabled in reset
`define BSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsd assertion failed");

`endif

@@ src/bsd_pkg.sv @@
// types and codes for the bounded sequence deque unit
// no dependencies
`timescale 1ns / 1ps

package bsd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_LOAD = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } ctrl_cmd_t;

endpackage

@@ src/bsd_ctrl.sv @@
// controller state machine: accept, execute, load result
// depends on bsd_pkg
`timescale 1ns / 1ps

module bsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bsd_pkg::ctrl_cmd_t ctrl_o
);
  import bsd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_LOAD;
      ST_LOAD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      ST_EXEC: ctrl_o.execute = 1'b1;
      ST_LOAD: ctrl_o.load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (ctrl_o.load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/bsd_datapath.sv @@
// datapath: row of shifting cells, count, status and result register
// depends on bsd_pkg
`timescale 1ns / 1ps

module bsd_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsd_pkg::ctrl_cmd_t ctrl_i,
  input  bsd_pkg::in_item_t  in_item_i,
  output bsd_pkg::out_item_t out_item_o
);
  import bsd_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = (CW > 5) ? CW : 5;

  in_item_t        req_q;
  logic [CW-1:0]   count_q, count_d;
  logic [31:0]     cells_q [CAPACITY];
  logic [31:0]     cells_d [CAPACITY];
  status_e         status_q, status_d;
  out_item_t       res_q;

  logic [IW-1:0]   pos_ext, cnt_ext, eff;
  logic            is_ins, is_ers, full, empty, do_ins, do_ers;
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   back_idx;
  logic [CW+4:0]   cnt_wide;

  assign pos_ext = IW'(req_q.position);
  assign cnt_ext = IW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);

  always_comb begin
    is_ins = 1'b0;
    is_ers = 1'b0;
    eff    = '0;
    case (req_q.command)
      CMD_PUSH_FRONT: is_ins = 1'b1;
      CMD_PUSH_BACK: begin
        is_ins = 1'b1;
        eff    = cnt_ext;
      end
      CMD_POP_FRONT: is_ers = 1'b1;
      CMD_POP_BACK: begin
        is_ers = 1'b1;
        eff    = cnt_ext - IW'(1);
      end
      CMD_INSERT: begin
        is_ins = 1'b1;
        eff    = pos_ext;
      end
      CMD_ERASE: begin
        is_ers = 1'b1;
        eff    = pos_ext;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_d = STAT_REJECT;
    if (is_ins) begin
      if (full) status_d = STAT_FULL;
      else if (eff > cnt_ext) status_d = STAT_REJECT;
      else status_d = STAT_DONE;
    end else if (is_ers) begin
      if (empty || eff >= cnt_ext) status_d = STAT_REJECT;
      else status_d = STAT_DONE;
    end
  end

  assign do_ins = is_ins && (status_d == STAT_DONE);
  assign do_ers = is_ers && (status_d == STAT_DONE);

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + CW'(1);
    else if (do_ers) count_d = count_q - CW'(1);
  end

  // each cell picks hold, left neighbor, right neighbor or the new value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [IW-1:0] idx;
    assign idx = IW'(i);
    always_comb begin
      cells_d[i] = cells_q[i];
      if (do_ins) begin
        if (idx == eff) begin
          cells_d[i] = req_q.value;
        end else if (idx > eff) begin
          if (i > 0) cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_ers) begin
        if (idx >= eff && i < CAPACITY - 1) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (ctrl_i.execute) cells_q[i] <= cells_d[i];
    end
  end

  assign cnt_m1   = count_q - CW'(1);
  assign back_idx = cnt_m1[AW-1:0];
  assign cnt_wide = {5'd0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) req_q <= in_item_i;
    if (ctrl_i.execute) status_q <= status_d;
    if (ctrl_i.load) begin
      res_q.front_value <= empty ? '0 : cells_q[0];
      res_q.back_value  <= empty ? '0 : cells_q[back_idx];
      res_q.entry_count <= cnt_wide[4:0];
      res_q.is_empty    <= empty;
      res_q.status      <= status_q;
    end
  end

  assign out_item_o = res_q;

endmodule

@@ src/bounded_sequence_deque_unit.sv @@
// top level of the bounded sequence deque unit
// depends on bsd_pkg, bsd_ctrl, bsd_datapath
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------
//   in      | in_valid_i / in_ready_o  | in_item_i  (in_item_t)
//   out     | out_valid_o / out_ready_i| out_item_o (out_item_t)
//
// an item passes through three steps: capture, cell update, result load
// the row of cells shifts in parallel; the result register
// is loaded from cell zero and the cell at count minus one
// a new item is taken while a result still waits in the output register
// reset clears the count; cell contents are unknown until written
`timescale 1ns / 1ps

module bounded_sequence_deque_unit #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsd_pkg::out_item_t out_item_o
);
  import bsd_pkg::*;

  ctrl_cmd_t ctrl;

  bsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  bsd_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ src/bsd_checker.sv @@
// port-level checks for the bounded sequence deque unit, bound to the top
// depends on bsd_pkg and bounded_sequence_deque_unit_assert.svh
`timescale 1ns / 1ps
`include "bounded_sequence_deque_unit_assert.svh"

module bsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bsd_pkg::out_item_t out_item_o
);
  import bsd_pkg::*;

  logic in_acc;
  logic out_stall;
  logic res_empty;
  logic cnt_zero;
  logic ends_zero;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign res_empty = out_valid_o && out_item_o.is_empty;
  assign cnt_zero  = (out_item_o.entry_count == 5'd0);
  assign ends_zero = (out_item_o.front_value == 32'sd0) && (out_item_o.back_value == 32'sd0);

  // stalled result holds
  `BSD_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_item_o))
  // block is busy right after taking an item
  `BSD_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_o)
  // empty flag agrees with count
  `BSD_ASSERT_NOW(a_empty_flag, res_empty, cnt_zero)
  // empty store shows zero at both ends
  `BSD_ASSERT_NOW(a_empty_zero, res_empty, ends_zero)

endmodule

bind bounded_sequence_deque_unit bsd_checker u_bsd_checker (.*);
